// ===== src/mda_pkg.sv =====
// shared constants and types for the minkowski distance accumulator
`default_nettype none
package mda_pkg;

  localparam int ELEM_WIDTH = 12;
  localparam int AD_W       = ELEM_WIDTH;
  localparam int ACC_W      = 64;
  localparam int OP_W       = 32;
  localparam int POW_W      = 3;

  localparam logic [POW_W-1:0] POW_CHEB  = 3'd0;
  localparam logic [POW_W-1:0] POW_MANH  = 3'd1;
  localparam logic [POW_W-1:0] POW_MAX   = 3'd4;
  localparam logic [POW_W-1:0] POW_RESET = 3'd2;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] a;
    logic [OP_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [ACC_W-1:0] prod;
  } mul_rsp_t;

endpackage
`default_nettype wire

// ===== src/minkowski_distance_accumulator.sv =====
// top level of the minkowski distance accumulator: sequencer, accumulator, root search
//
//  channel | direction | handshake                  | payload
//  in_     | input     | in_tvalid / in_tready      | tdata: x_elem, y_elem; tlast: last
//  out_    | output    | out_tvalid / out_tready    | tdata: distance; tuser: overflow
//  cfg_    | input     | cfg_valid / cfg_ready      | data: power
//
// an item at power 0 or 1 skips the multiplier; at powers 2..4 the shared multiplier
// raises |x-y| to the power, one multiply after another
// a last item at powers 2..4 adds the root search over 32 result bits, each bit tested
// by raising the candidate to the power, then the hand-off to the output register
// synchronous active-low reset: power returns to 2, accumulator and flag clear
// in_tready is high only while the sequencer is idle; a result waiting on out_tready
// does not block the next items, only the next result
`default_nettype none
module minkowski_distance_accumulator
  import mda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // x_elem [11:0], y_elem [23:12]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // distance [31:0]
  output logic [0:0]       out_tuser,  // overflow [0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data    // power [2:0]
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_POW  = 8'b00000010,
    S_EMUL = 8'b00000100,
    S_ACC  = 8'b00001000,
    S_FIN  = 8'b00010000,
    S_RBIT = 8'b00100000,
    S_RMUL = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [POW_W-1:0]  power_r;
  logic [POW_W-1:0]  p_r, p_nxt;
  logic [AD_W-1:0]   ad_r, ad_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  term_r, term_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              sat_r, sat_nxt;
  logic [OP_W-1:0]   root_r, root_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [OP_W-1:0]   dist_r, dist_nxt;
  logic              dovf_r, dovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OP_W-1:0]   out_dist_r, out_dist_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  mul_req_t          mreq;
  mul_rsp_t          mrsp;

  logic signed [ELEM_WIDTH-1:0] x_w, y_w;
  logic signed [ELEM_WIDTH:0]   d_w;
  logic [ELEM_WIDTH:0]          dabs_w;
  logic [ACC_W:0]               acc_sum_w;
  logic [OP_W-1:0]              cand_w;
  logic [ACC_W-1:0]             ad_ext_w;
  logic [OP_W-1:0]              ad_op_w;
  logic                         pass_w;
  logic                         decide_w;
  logic                         in_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // element difference, both read as ELEM_WIDTH-bit signed
  assign x_w    = signed'(in_tdata[ELEM_WIDTH-1:0]);
  assign y_w    = signed'(in_tdata[12 +: ELEM_WIDTH]);
  assign d_w    = (ELEM_WIDTH+1)'(x_w) - (ELEM_WIDTH+1)'(y_w);
  assign dabs_w = d_w[ELEM_WIDTH] ? (ELEM_WIDTH+1)'(-d_w) : (ELEM_WIDTH+1)'(d_w);

  assign ad_ext_w  = ACC_W'(ad_r);
  assign ad_op_w   = OP_W'(ad_r);
  assign acc_sum_w = {1'b0, acc_r} + {1'b0, term_r};
  // root candidate: current partial root with the bit under test set
  assign cand_w    = root_r | (OP_W'(1) << bit_r);

  // candidate power fits and is no larger than the accumulator
  assign pass_w   = !mrsp.ovf && (mrsp.prod <= acc_r);
  assign decide_w = (state_r == S_RMUL) && mrsp.done && (mrsp.ovf || cnt_r == 2'd1);

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    ad_nxt        = ad_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    term_nxt      = term_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    dist_nxt      = dist_r;
    dovf_nxt      = dovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_dist_nxt  = out_dist_r;
    out_ovf_nxt   = out_ovf_r;
    mreq.start    = 1'b0;
    mreq.a        = ad_ext_w;
    mreq.b        = ad_op_w;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ad_nxt    = dabs_w[AD_W-1:0];
          last_nxt  = in_tlast;
          // powers above four behave as four
          p_nxt     = (power_r > POW_MAX) ? POW_MAX : power_r;
          cnt_nxt   = 2'(p_nxt - 3'd1);
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        if (p_r == POW_CHEB || p_r == POW_MANH) begin
          term_nxt  = ad_ext_w;
          state_nxt = S_ACC;
        end else begin
          mreq.start = 1'b1;
          state_nxt  = S_EMUL;
        end
      end
      S_EMUL: begin
        if (mrsp.done) begin
          term_nxt = mrsp.prod;
          cnt_nxt  = cnt_r - 2'd1;
          if (cnt_r == 2'd1) begin
            state_nxt = S_ACC;
          end else begin
            mreq.start = 1'b1;
            mreq.a     = mrsp.prod;
          end
        end
      end
      S_ACC: begin
        if (p_r == POW_CHEB) begin
          if (ad_ext_w > acc_r) acc_nxt = ad_ext_w;
        end else if (acc_sum_w[ACC_W]) begin
          acc_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum_w[ACC_W-1:0];
        end
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (p_r == POW_CHEB || p_r == POW_MANH) begin
          if (acc_r[ACC_W-1:OP_W] != '0) begin
            dist_nxt = '1;
            dovf_nxt = 1'b1;
          end else begin
            dist_nxt = acc_r[OP_W-1:0];
            dovf_nxt = sat_r;
          end
          state_nxt = S_EMIT;
        end else begin
          root_nxt  = '0;
          bit_nxt   = 5'd31;
          state_nxt = S_RBIT;
        end
      end
      S_RBIT: begin
        cnt_nxt    = 2'(p_r - 3'd1);
        mreq.start = 1'b1;
        mreq.a     = ACC_W'(cand_w);
        mreq.b     = cand_w;
        state_nxt  = S_RMUL;
      end
      S_RMUL: begin
        if (decide_w) begin
          if (pass_w) root_nxt = cand_w;
          if (bit_r == 5'd0) begin
            dist_nxt  = pass_w ? cand_w : root_r;
            dovf_nxt  = sat_r;
            state_nxt = S_EMIT;
          end else begin
            bit_nxt   = bit_r - 5'd1;
            state_nxt = S_RBIT;
          end
        end else if (mrsp.done) begin
          cnt_nxt    = cnt_r - 2'd1;
          mreq.start = 1'b1;
          mreq.a     = mrsp.prod;
          mreq.b     = cand_w;
        end
      end
      S_EMIT: begin
        // hand off once the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_r;
          out_ovf_nxt   = dovf_r;
          acc_nxt       = '0;
          sat_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      power_r     <= POW_RESET;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) power_r <= cfg_data;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    ad_r       <= ad_nxt;
    last_r     <= last_nxt;
    cnt_r      <= cnt_nxt;
    term_r     <= term_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    dist_r     <= dist_nxt;
    dovf_r     <= dovf_nxt;
    out_dist_r <= out_dist_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  mda_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_dist_r;
  assign out_tuser[0] = out_ovf_r;

endmodule
`default_nettype wire

// ===== src/mda_mul.sv =====
// shared 64x32 multiplier with an overflow flag, built from two 32x32 partial products
`default_nettype none
module mda_mul
  import mda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_CMB  = 4'b1000
  } mstate_t;

  mstate_t            state_r, state_nxt;
  logic [ACC_W-1:0]   a_r;
  logic [OP_W-1:0]    b_r;
  logic [2*OP_W-1:0]  prod_lo_r;
  logic [2*OP_W-1:0]  prod_hi_r;
  logic [ACC_W:0]     sum_w;
  logic [OP_W-1:0]    mul_a_w;
  logic [2*OP_W-1:0]  mul_p_w;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  if (req.start) state_nxt = M_LO;
      M_LO:    state_nxt = M_HI;
      M_HI:    state_nxt = M_CMB;
      M_CMB:   state_nxt = req.start ? M_LO : M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one 32x32 multiplier, low half of a first, then high half
  assign mul_a_w = (state_r == M_HI) ? a_r[ACC_W-1:OP_W] : a_r[OP_W-1:0];
  assign mul_p_w = mul_a_w * b_r;

  // operands latch on start, partial products one per cycle
  always_ff @(posedge clk) begin
    if (req.start && (state_r == M_IDLE || state_r == M_CMB)) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (state_r == M_LO) prod_lo_r <= mul_p_w;
    if (state_r == M_HI) prod_hi_r <= mul_p_w;
  end

  assign sum_w = {1'b0, prod_lo_r} + {1'b0, prod_hi_r[OP_W-1:0], {OP_W{1'b0}}};

  always_comb begin
    rsp.done = (state_r == M_CMB);
    rsp.ovf  = (prod_hi_r[2*OP_W-1:OP_W] != '0) || sum_w[ACC_W];
    rsp.prod = sum_w[ACC_W-1:0];
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the minkowski distance accumulator
`timescale 1ns / 1ps
module testbench;
  import mda_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 5_000_000;   // several times the slowest run
  localparam int          SETTLE_CYCLES = 64;         // settling wait before a power write
  localparam int          DRAIN_CYCLES  = 400;        // wait after the last result before finishing
  localparam int          LONG_VECTOR   = 16;         // run of max-difference pairs
  localparam int          ITEMS_PER_PHASE = 100;

  // distance orders that the package gives no name
  localparam logic [POW_W-1:0] POW_CUBE  = 3'd3;
  localparam logic [POW_W-1:0] POW_OVER5 = 3'd5;
  localparam logic [POW_W-1:0] POW_OVER6 = 3'd6;
  localparam logic [POW_W-1:0] POW_OVER7 = 3'd7;

  localparam logic [ELEM_WIDTH-1:0] C_MIN = 12'h800;  // -2048
  localparam logic [ELEM_WIDTH-1:0] C_MAX = 12'h7FF;  //  2047
  localparam logic [ELEM_WIDTH-1:0] C_NEG1 = 12'hFFF; //  -1

  typedef struct packed {
    logic [31:0] distance;
    logic        overflow;
  } dist_rec_t;

  // one row of the directed plan: optional power write, then one coordinate pair
  typedef struct packed {
    logic                  set_pow;
    logic [POW_W-1:0]      pow;
    logic [ELEM_WIDTH-1:0] x;
    logic [ELEM_WIDTH-1:0] y;
    logic                  last;
    logic                  typed;     // expected result written out below
    logic [31:0]           distance;
    logic                  overflow;
  } pair_row_t;

  localparam int PLAN_ROWS = 23;
  localparam pair_row_t PLAN [PLAN_ROWS] = '{
    // reset order is 2: zero vector, then the widest single pair
    '{1'b0, POW_RESET, 12'h000, 12'h000, 1'b1, 1'b1, 32'd0,    1'b0},
    '{1'b0, POW_RESET, C_MAX,   C_MIN,   1'b1, 1'b1, 32'd4095, 1'b0},
    '{1'b0, POW_RESET, C_MIN,   C_MAX,   1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_RESET, 12'h003, 12'h000, 1'b1, 1'b0, 32'd0,    1'b0},
    // chebyshev keeps the largest difference
    '{1'b1, POW_CHEB,  C_MIN,   C_MIN,   1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_CHEB,  12'h005, 12'hFFB, 1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_CHEB,  C_NEG1,  12'h001, 1'b1, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_CHEB,  C_MAX,   C_MIN,   1'b1, 1'b1, 32'd4095, 1'b0},
    // manhattan sum
    '{1'b1, POW_MANH,  C_MAX,   C_MIN,   1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_MANH,  C_MIN,   C_MAX,   1'b1, 1'b1, 32'd8190, 1'b0},
    // cube and fourth power roots
    '{1'b1, POW_CUBE,  C_MAX,   C_MIN,   1'b1, 1'b1, 32'd4095, 1'b0},
    '{1'b0, POW_CUBE,  12'd100, 12'h000, 1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_CUBE,  12'h001, 12'h000, 1'b1, 1'b0, 32'd0,    1'b0},
    '{1'b1, POW_MAX,   C_MAX,   C_MIN,   1'b1, 1'b1, 32'd4095, 1'b0},
    // orders above four act as four
    '{1'b1, POW_OVER5, C_MIN,   C_MAX,   1'b1, 1'b1, 32'd4095, 1'b0},
    '{1'b1, POW_OVER7, 12'd10,  12'h000, 1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b0, POW_OVER7, 12'h000, 12'h007, 1'b1, 1'b0, 32'd0,    1'b0},
    // order switched mid-vector: a fourth-power sum read out as a manhattan sum
    '{1'b1, POW_MAX,   C_MAX,   C_MIN,   1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b1, POW_MANH,  12'h000, 12'h000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
    // and read out as a chebyshev max
    '{1'b1, POW_MAX,   C_MAX,   C_MIN,   1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b1, POW_CHEB,  12'h001, 12'h000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{1'b1, POW_OVER6, 12'h000, 12'h001, 1'b0, 1'b0, 32'd0,    1'b0},
    '{1'b1, POW_RESET, C_NEG1,  C_NEG1,  1'b1, 1'b0, 32'd0,    1'b0}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;  // x_elem [11:0], y_elem [23:12]
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;        // distance [31:0]
  logic [0:0]            out_tuser;        // overflow [0]
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [POW_W-1:0]      cfg_data   = '0;  // power [2:0]

  // predictor state, mirrors the block after reset
  logic [POW_W-1:0]      power_q    = POW_RESET;
  logic [ACC_W-1:0]      acc_q      = '0;
  logic                  sat_q      = 1'b0;

  dist_rec_t             owed_distances[$];
  int                    mismatches = 0;
  int                    idle_pct   = 0;   // sender idle chance per cycle
  int                    stall_pct  = 0;   // receiver stall chance per cycle

  minkowski_distance_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // floor k-th root by bitwise search; c^4 of a 32-bit c fits in 128 bits
  function automatic logic [31:0] floor_root(input logic [ACC_W-1:0] a,
                                             input logic [POW_W-1:0] k);
    logic [31:0]  r;
    logic [31:0]  c;
    logic [127:0] pw;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c  = r | (32'd1 << b);
      pw = 128'd1;
      for (int i = 0; i < k; i++) pw = pw * {96'd0, c};
      if (pw <= {64'd0, a}) r = c;
    end
    return r;
  endfunction

  // fold one coordinate pair into the running distance; on last, produce the result
  task automatic fold_pair(input logic [ELEM_WIDTH-1:0] xv, input logic [ELEM_WIDTH-1:0] yv,
                           input logic lst, output logic emit, output dist_rec_t res);
    logic signed [ELEM_WIDTH:0] diff;
    logic [ACC_W-1:0]           mag;
    logic [ACC_W-1:0]           term;
    logic [POW_W-1:0]           ord;
    ord  = (power_q > POW_MAX) ? POW_MAX : power_q;
    diff = $signed({xv[ELEM_WIDTH-1], xv}) - $signed({yv[ELEM_WIDTH-1], yv});
    mag  = '0;
    mag[ELEM_WIDTH:0] = diff[ELEM_WIDTH] ? -diff : diff;
    if (ord == POW_CHEB) begin
      if (mag > acc_q) acc_q = mag;
    end else begin
      term = mag;
      for (int i = 1; i < ord; i++) term = term * mag;
      // sum holds at all ones once it would wrap
      if (acc_q > ({ACC_W{1'b1}} - term)) begin
        acc_q = {ACC_W{1'b1}};
        sat_q = 1'b1;
      end else begin
        acc_q = acc_q + term;
      end
    end
    emit = lst;
    res  = '0;
    if (lst) begin
      res.overflow = sat_q;
      if (ord <= POW_MANH) begin
        if (acc_q > 64'h0000_0000_FFFF_FFFF) begin
          res.distance = 32'hFFFF_FFFF;
          res.overflow = 1'b1;
        end else begin
          res.distance = acc_q[31:0];
        end
      end else begin
        res.distance = floor_root(acc_q, ord);
      end
      acc_q = '0;
      sat_q = 1'b0;
    end
  endtask

  // one input transaction; the expectation is queued when the pair is taken
  task automatic send_pair(input logic [ELEM_WIDTH-1:0] xv, input logic [ELEM_WIDTH-1:0] yv,
                           input logic lst, input logic typed, input dist_rec_t typed_rec);
    logic      emit;
    dist_rec_t got;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yv, xv};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    fold_pair(xv, yv, lst, emit, got);
    if (emit) owed_distances.push_back(typed ? typed_rec : got);
  endtask

  // power is only changed once the block has gone quiet
  task automatic write_power(input logic [POW_W-1:0] p);
    in_tvalid <= 1'b0;
    while (owed_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    power_q = p;
  endtask

  // random coordinate with the extremes weighted in
  function automatic logic [ELEM_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return C_NEG1;
      default: return ELEM_WIDTH'($urandom_range(0, (1 << ELEM_WIDTH) - 1));
    endcase
  endfunction

  // compare each result transaction against the oldest expectation
  always @(posedge clk) begin : check_distances
    dist_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_distances.size() == 0) begin
        $error("unexpected result: distance %0d overflow %0d", out_tdata, out_tuser[0]);
        mismatches++;
      end else begin
        want = owed_distances.pop_front();
        if (out_tdata !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int  len;
    int  sent;
    logic lst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan, no idling
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].set_pow) write_power(PLAN[r].pow);
      send_pair(PLAN[r].x, PLAN[r].y, PLAN[r].last, PLAN[r].typed,
                dist_rec_t'{PLAN[r].distance, PLAN[r].overflow});
    end

    // a fourth-power vector of widest pairs builds a large sum
    write_power(POW_MAX);
    for (int i = 0; i < LONG_VECTOR; i++) begin
      send_pair(C_MAX, C_MIN, i == LONG_VECTOR - 1, 1'b0, '0);
    end
    // the next vector must start from a cleared sum
    send_pair(12'h002, 12'h000, 1'b1, 1'b0, '0);

    // random vectors under four idling schemes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 63; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 2) == 0) write_power(POW_W'($urandom_range(0, 7)));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          lst = (i == len - 1);
          // occasional order change inside a vector
          if (!lst && i != 0 && $urandom_range(0, 19) == 0)
            write_power(POW_W'($urandom_range(0, 7)));
          send_pair(pick_coord(), pick_coord(), lst, 1'b0, '0);
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (owed_distances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mda_pkg.sv
src/mda_mul.sv
src/minkowski_distance_accumulator.sv
sim/testbench.sv
